### rtl/pss_pkg.sv
package pss_pkg;

  localparam int unsigned PNS_W     = 47;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = 6;

  localparam logic [PNS_W-1:0] NS_PER_S_P  = 47'd1_000_000_000;
  localparam logic [63:0]      NS_PER_S_64 = 64'd1_000_000_000;
  localparam logic [63:0]      TX_LEN_NS   = 64'd110_592_000_000;
  localparam logic [63:0]      MAX_LEAD_NS = 64'd10_000_000_000;
  localparam logic [63:0]      MIN_LEAD_NS = 64'd2_000_000_000;
  localparam logic [63:0]      ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] CFG_MAX_UNC  = 3'd0;
  localparam logic [2:0] CFG_MAX_HOLD = 3'd1;
  localparam logic [2:0] CFG_MIN_UTC  = 3'd2;
  localparam logic [2:0] CFG_MAX_UTC  = 3'd3;
  localparam logic [2:0] CFG_EXPIRY   = 3'd4;

  localparam logic [2:0] OUT_ARMABLE   = 3'd0;
  localparam logic [2:0] OUT_NOT_READY = 3'd1;
  localparam logic [2:0] OUT_CLOCK_REJ = 3'd2;
  localparam logic [2:0] OUT_NO_SLOT   = 3'd3;
  localparam logic [2:0] OUT_EXPIRY    = 3'd4;
  localparam logic [2:0] OUT_WRITTEN   = 3'd5;

  localparam logic [1:0] CLK_SYNC = 2'd1;
  localparam logic [1:0] CLK_HOLD = 2'd2;

  typedef struct packed {
    logic [16:0] period_sec;
    logic [16:0] phase_s;
  } entry_t;

  typedef struct packed {
    logic [63:0] max_unc;
    logic [63:0] max_hold;
    logic [63:0] min_utc;
    logic [63:0] max_utc;
    logic [63:0] expiry_ns;
  } cfg_t;

endpackage

### rtl/pss_if.sv
interface pss_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [2:0]  entry_index;
  logic [16:0] period_sec;
  logic [16:0] phase_s;
  logic [63:0] now_ns;
  logic [63:0] watermark_ns;
  logic [1:0]  clk_state;
  logic        leap_normal;
  logic [63:0] unc_ns;
  logic [63:0] sync_age;
  logic        ready_req;

  modport source (
    output valid, func, entry_index, period_sec, phase_s, now_ns, watermark_ns,
           clk_state, leap_normal, unc_ns, sync_age, ready_req,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, period_sec, phase_s, now_ns, watermark_ns,
           clk_state, leap_normal, unc_ns, sync_age, ready_req,
    output ready
  );
endinterface

interface pss_out_if;
  logic        valid;
  logic        ready;
  logic        arm;
  logic [63:0] slot_ns;
  logic [2:0]  outcome;

  modport source (output valid, arm, slot_ns, outcome, input ready);
  modport sink (input valid, arm, slot_ns, outcome, output ready);
endinterface

### rtl/pss_cfg_regs.sv
module pss_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata,
  output pss_pkg::cfg_t    cfg
);
  import pss_pkg::*;

  logic [63:0] max_unc_r;
  logic [63:0] max_hold_r;
  logic [63:0] min_utc_r;
  logic [63:0] max_utc_r;
  logic [31:0] expiry_s_r;
  logic [63:0] expiry_ns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_unc_r   <= 64'd1_000_000;
      max_hold_r  <= '0;
      min_utc_r   <= '0;
      max_utc_r   <= ALL_ONES;
      expiry_s_r  <= '0;
      expiry_ns_r <= '0;
    end else begin
      expiry_ns_r <= 64'(expiry_s_r) * NS_PER_S_64;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_UNC:  max_unc_r  <= cfg_wdata;
          CFG_MAX_HOLD: max_hold_r <= cfg_wdata;
          CFG_MIN_UTC:  min_utc_r  <= cfg_wdata;
          CFG_MAX_UTC:  max_utc_r  <= cfg_wdata;
          CFG_EXPIRY:   expiry_s_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.max_unc   = max_unc_r;
  assign cfg.max_hold  = max_hold_r;
  assign cfg.min_utc   = min_utc_r;
  assign cfg.max_utc   = max_utc_r;
  assign cfg.expiry_ns = expiry_ns_r;

endmodule

### rtl/pss_sched_mem.sv
module pss_sched_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  pss_pkg::entry_t   wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output pss_pkg::entry_t   rdata,
  output logic              rvalid
);
  import pss_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           rdata_r;
  logic             rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid_r <= vld_r[raddr];
      end
    end
  end

  assign rdata  = rdata_r;
  assign rvalid = rvalid_r;

endmodule

### rtl/pss_rem_div.sv
module pss_rem_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [63:0]                dividend,
  input  logic [pss_pkg::PNS_W-1:0]  divisor,
  output logic                       done,
  output logic [pss_pkg::PNS_W-1:0]  rem
);
  import pss_pkg::*;

  logic [63:0]      dvd_r;
  logic [PNS_W-1:0] dsr_r;
  logic [PNS_W-1:0] rem_r;
  logic [PNS_W-1:0] rem_nxt;
  logic [PNS_W:0]   trial;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // restoring step, one quotient bit per cycle; only the remainder is kept
  always_comb begin
    trial = {rem_r, dvd_r[63]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = PNS_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[PNS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[62:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/periodic_slot_selector_top.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   func, entry_index, period_sec, phase_s, now_ns,
//                              watermark_ns, clk_state, leap_normal,
//                              unc_ns, sync_age, ready_req
// out_ch    out  valid/ready   arm, slot_ns, outcome
// cfg_*     in   cfg_we        cfg_index, cfg_wdata (no read-back)
//
// One transaction at a time. A table write or a rejected poll goes straight to S_DONE.
// A full poll reads every table entry and runs the 64-step remainder unit (one bit
// per cycle) once for each filled entry with a nonzero period.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// A result waits in the output register while out_ch.ready is low; the block
// holds its finished result until that register frees up.
module periodic_slot_selector_top #(
  parameter int unsigned MAX_SCHEDULES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  pss_in_if.sink      in_ch,
  pss_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import pss_pkg::*;

  localparam int unsigned AW = (MAX_SCHEDULES > 1) ? $clog2(MAX_SCHEDULES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SCHEDULES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_DGO, S_DIV, S_SLOT, S_ADJ, S_CMP, S_LEAD, S_EXP, S_DONE
  } state_t;

  cfg_t             cfg;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             rd_valid;
  logic             mem_we;
  logic             mem_re;
  logic             div_start;
  logic             div_done;
  logic [PNS_W-1:0] div_rem;
  logic             in_acc;
  logic             clock_ok;

  state_t           state_r,     state_nxt;
  logic [AW-1:0]    idx_r,       idx_nxt;
  logic [63:0]      now_r,       now_nxt;
  logic [63:0]      wm_r,        wm_nxt;
  logic             have_r,      have_nxt;
  logic [63:0]      cand_r,      cand_nxt;
  logic [PNS_W-1:0] pns_r,       pns_nxt;
  logic [PNS_W-1:0] add_r,       add_nxt;
  logic [63:0]      slot_r,      slot_nxt;
  logic [63:0]      lead_r,      lead_nxt;
  logic             win_r,       win_nxt;
  logic             res_arm_r,   res_arm_nxt;
  logic [63:0]      res_slot_r,  res_slot_nxt;
  logic [2:0]       res_code_r,  res_code_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_arm_r,   out_arm_nxt;
  logic [63:0]      out_slot_r,  out_slot_nxt;
  logic [2:0]       out_code_r,  out_code_nxt;

  logic [63:0]      base;
  logic [64:0]      sum65;
  logic [64:0]      next65;

  pss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign wr_entry.period_sec = in_ch.period_sec;
  assign wr_entry.phase_s    = in_ch.phase_s;

  pss_sched_mem #(
    .DEPTH (MAX_SCHEDULES),
    .AW    (AW)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (mem_we),
    .waddr  (AW'(in_ch.entry_index)),
    .wdata  (wr_entry),
    .re     (mem_re),
    .raddr  (idx_r),
    .rdata  (rd_entry),
    .rvalid (rd_valid)
  );

  pss_rem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (now_r),
    .divisor  (pns_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign mem_we      = in_acc && in_ch.func && (32'(in_ch.entry_index) < MAX_SCHEDULES);
  assign mem_re      = (state_r == S_RD);
  assign div_start   = (state_r == S_DGO);

  assign clock_ok = ((in_ch.clk_state == CLK_SYNC) || (in_ch.clk_state == CLK_HOLD))
                 && in_ch.leap_normal
                 && (in_ch.unc_ns <= cfg.max_unc)
                 && !((in_ch.clk_state == CLK_HOLD)
                      && ((cfg.max_hold == 64'd0) || (in_ch.sync_age > cfg.max_hold)))
                 && (in_ch.now_ns >= cfg.min_utc)
                 && (in_ch.now_ns < cfg.max_utc);

  assign base   = now_r - 64'(div_rem);
  assign sum65  = {1'b0, base} + 65'(add_r);
  assign next65 = {1'b0, slot_r} + 65'(pns_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    wm_nxt        = wm_r;
    have_nxt      = have_r;
    cand_nxt      = cand_r;
    pns_nxt       = pns_r;
    add_nxt       = add_r;
    slot_nxt      = slot_r;
    lead_nxt      = lead_r;
    win_nxt       = win_r;
    res_arm_nxt   = res_arm_r;
    res_slot_nxt  = res_slot_r;
    res_code_nxt  = res_code_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_arm_nxt   = out_arm_r;
    out_slot_nxt  = out_slot_r;
    out_code_nxt  = out_code_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_arm_nxt  = 1'b0;
          res_slot_nxt = ALL_ONES;
          now_nxt      = in_ch.now_ns;
          wm_nxt       = in_ch.watermark_ns;
          idx_nxt      = '0;
          have_nxt     = 1'b0;
          state_nxt    = S_DONE;
          if (in_ch.func) begin
            res_code_nxt = OUT_WRITTEN;
          end else if (!in_ch.ready_req) begin
            res_code_nxt = OUT_NOT_READY;
          end else if (!clock_ok) begin
            res_code_nxt = OUT_CLOCK_REJ;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        pns_nxt = PNS_W'(rd_entry.period_sec) * NS_PER_S_P;
        add_nxt = PNS_W'({1'b0, rd_entry.phase_s} + 18'd1) * NS_PER_S_P;
        if (rd_valid && (rd_entry.period_sec != 17'd0)) begin
          state_nxt = S_DGO;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_LEAD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        slot_nxt  = sum65[63:0];
        state_nxt = S_ADJ;
        if (sum65[64]) begin
          state_nxt = (idx_r == LAST_IDX) ? S_LEAD : S_RD;
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_ADJ: begin
        state_nxt = S_CMP;
        if (slot_r <= now_r) begin
          slot_nxt = next65[63:0];
          if (next65[64]) begin
            state_nxt = (idx_r == LAST_IDX) ? S_LEAD : S_RD;
            if (idx_r != LAST_IDX) begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
      end
      S_CMP: begin
        if ((slot_r > wm_r) && (!have_r || (slot_r < cand_r))) begin
          cand_nxt = slot_r;
          have_nxt = 1'b1;
        end
        state_nxt = (idx_r == LAST_IDX) ? S_LEAD : S_RD;
        if (idx_r != LAST_IDX) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LEAD: begin
        win_nxt   = have_r && (cand_r > now_r);
        lead_nxt  = cand_r - now_r;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        state_nxt = S_DONE;
        if (!win_r || (lead_r > MAX_LEAD_NS) || (lead_r < MIN_LEAD_NS)) begin
          res_arm_nxt  = 1'b0;
          res_slot_nxt = ALL_ONES;
          res_code_nxt = OUT_NO_SLOT;
        end else if ((cfg.expiry_ns != 64'd0)
                     && ((cand_r >= cfg.expiry_ns)
                         || ((cfg.expiry_ns - cand_r) < TX_LEN_NS))) begin
          res_arm_nxt  = 1'b0;
          res_slot_nxt = cand_r;
          res_code_nxt = OUT_EXPIRY;
        end else begin
          res_arm_nxt  = 1'b1;
          res_slot_nxt = cand_r;
          res_code_nxt = OUT_ARMABLE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_arm_nxt   = res_arm_r;
          out_slot_nxt  = res_slot_r;
          out_code_nxt  = res_code_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      have_r      <= have_nxt;
    end
    now_r      <= now_nxt;
    wm_r       <= wm_nxt;
    cand_r     <= cand_nxt;
    pns_r      <= pns_nxt;
    add_r      <= add_nxt;
    slot_r     <= slot_nxt;
    lead_r     <= lead_nxt;
    win_r      <= win_nxt;
    res_arm_r  <= res_arm_nxt;
    res_slot_r <= res_slot_nxt;
    res_code_r <= res_code_nxt;
    out_arm_r  <= out_arm_nxt;
    out_slot_r <= out_slot_nxt;
    out_code_r <= out_code_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.arm     = out_arm_r;
  assign out_ch.slot_ns = out_slot_r;
  assign out_ch.outcome = out_code_r;

endmodule
